### rtl/ert_pkg.sv
// Shared constants, types and tables for the entity rotation transform.
`default_nettype none

package ert_pkg;

	// angle and coefficient formats
	localparam int ANGLE_BITS     = 16;
	localparam int COEF_FRAC_BITS = 16;
	localparam int WORK_FRAC      = 30;

	// stream field widths
	localparam int ANGLE_W      = 16;
	localparam int ORIGIN_W     = 32;
	localparam int ENTRY_W      = 18;
	localparam int N_ENTRY      = 9;
	localparam int ORIG_BUS_W   = 3 * ORIGIN_W;
	localparam int IN_TDATA_W   = 144;
	localparam int OUT_FIELDS_W = N_ENTRY * ENTRY_W + ORIG_BUS_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

	// turn values: full circle is 2^TURN_W
	localparam int TURN_W     = 32;
	localparam int TURN_SHIFT = TURN_W - ANGLE_BITS;
	localparam logic [TURN_W-1:0] ANGLE_MASK  = TURN_W'((64'd1 << ANGLE_BITS) - 64'd1);
	localparam logic [TURN_W-1:0] TURN_EIGHTH = TURN_W'(64'd1 << (TURN_W - 3));

	// CORDIC datapath
	localparam int CORDIC_STEPS  = 30;
	localparam int CORDIC_W      = 33;
	localparam int CORDIC_START  = 652032874;
	localparam int CORDIC_STAGES = CORDIC_STEPS + 2;

	// product / sum datapath
	localparam int WW     = 32;
	localparam int PROD_W = 2 * WW;
	localparam int SUM_W  = WW + 2;
	localparam logic signed [PROD_W-1:0] MUL_HALF = PROD_W'(64'd1 << (WORK_FRAC - 1));

	localparam int ENTRY_SHIFT = WORK_FRAC - COEF_FRAC_BITS;
	localparam logic signed [SUM_W-1:0] ENTRY_HALF = SUM_W'((64'd1 << ENTRY_SHIFT) >> 1);
	localparam logic signed [SUM_W-1:0] ENTRY_LIM  = SUM_W'(64'd1 << COEF_FRAC_BITS);

	localparam int COMPOSE_STAGES = 6;
	localparam int PIPE_STAGES    = CORDIC_STAGES + COMPOSE_STAGES;

	// matrix entry positions
	localparam int E00 = 0;
	localparam int E01 = 1;
	localparam int E02 = 2;
	localparam int E10 = 3;
	localparam int E11 = 4;
	localparam int E12 = 5;
	localparam int E20 = 6;
	localparam int E21 = 7;
	localparam int E22 = 8;

	// arctangent per step, 2^32 per turn
	localparam logic [TURN_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	typedef logic signed [ENTRY_W-1:0] entry_t;

	typedef struct packed {
		logic signed [WW-1:0] s;
		logic signed [WW-1:0] c;
	} sincos_t;

	typedef struct packed {
		sincos_t yaw;
		sincos_t pitch;
		sincos_t roll;
	} trig_t;

endpackage

`default_nettype wire

### rtl/ert_cordic.sv
// Pipelined CORDIC sine/cosine, one rotation step per stage.
`default_nettype none

module ert_cordic (
	input  logic                                 clk,
	input  logic [ert_pkg::CORDIC_STAGES-1:0]    en,
	input  logic [ert_pkg::TURN_W-1:0]           turn,
	output ert_pkg::sincos_t                     result
);
	import ert_pkg::*;

	// stage arrays: index 0 is the quadrant split, index i+1 follows step i
	quad_t                      quad_s [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] x_s    [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] y_s    [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] z_s    [CORDIC_STEPS+1];
	sincos_t                    fix_s;

	logic [TURN_W-1:0] biased;
	logic [TURN_W-1:0] resid;
	quad_t             quad;

	assign biased = turn + TURN_EIGHTH;
	assign quad   = quad_t'(biased[TURN_W-1 -: 2]);
	assign resid  = turn - {quad, {(TURN_W-2){1'b0}}};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			quad_s[0] <= quad;
			x_s[0]    <= CORDIC_W'(CORDIC_START);
			y_s[0]    <= '0;
			z_s[0]    <= CORDIC_W'(signed'(resid));
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [CORDIC_W-1:0] dx;
		logic signed [CORDIC_W-1:0] dy;
		logic signed [CORDIC_W-1:0] ang;

		assign dx  = y_s[i] >>> i;
		assign dy  = x_s[i] >>> i;
		assign ang = CORDIC_W'(ATAN_TURN[i]);

		always_ff @(posedge clk) begin
			if (en[i+1]) begin
				quad_s[i+1] <= quad_s[i];
				if (!z_s[i][CORDIC_W-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - ang;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + ang;
				end
			end
		end
	end

	// quarter-turn fold back
	always_ff @(posedge clk) begin
		if (en[CORDIC_STEPS+1]) begin
			unique case (quad_s[CORDIC_STEPS])
				QUAD_0: begin
					fix_s.c <= WW'(x_s[CORDIC_STEPS]);
					fix_s.s <= WW'(y_s[CORDIC_STEPS]);
				end
				QUAD_1: begin
					fix_s.c <= WW'(-y_s[CORDIC_STEPS]);
					fix_s.s <= WW'(x_s[CORDIC_STEPS]);
				end
				QUAD_2: begin
					fix_s.c <= WW'(-x_s[CORDIC_STEPS]);
					fix_s.s <= WW'(-y_s[CORDIC_STEPS]);
				end
				QUAD_3: begin
					fix_s.c <= WW'(y_s[CORDIC_STEPS]);
					fix_s.s <= WW'(-x_s[CORDIC_STEPS]);
				end
				default: begin
					fix_s.c <= WW'(x_s[CORDIC_STEPS]);
					fix_s.s <= WW'(y_s[CORDIC_STEPS]);
				end
			endcase
		end
	end

	assign result = fix_s;

endmodule

`default_nettype wire

### rtl/ert_compose.sv
// Matrix composition: products, rounding, sums and entry saturation.
`default_nettype none

module ert_compose (
	input  logic                                 clk,
	input  logic [ert_pkg::COMPOSE_STAGES-1:0]   en,
	input  ert_pkg::trig_t                       trig,
	output ert_pkg::entry_t                      rot [ert_pkg::N_ENTRY]
);
	import ert_pkg::*;

	function automatic logic signed [WW-1:0] rmul(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] r;
		r = (p + MUL_HALF) >>> WORK_FRAC;
		return WW'(r);
	endfunction

	function automatic entry_t to_entry(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		r = (v + ENTRY_HALF) >>> ENTRY_SHIFT;
		if (r > ENTRY_LIM) begin
			r = ENTRY_LIM;
		end else if (r < -ENTRY_LIM) begin
			r = -ENTRY_LIM;
		end
		return ENTRY_W'(r);
	endfunction

	logic signed [WW-1:0] sa, ca, sb, cb, sg, cg;

	assign sa = trig.yaw.s;
	assign ca = trig.yaw.c;
	assign sb = trig.pitch.s;
	assign cb = trig.pitch.c;
	assign sg = trig.roll.s;
	assign cg = trig.roll.c;

	// s1: raw pair products
	logic signed [PROD_W-1:0] ca_cb_s1, ca_sb_s1, sa_cg_s1, sa_sg_s1, sa_cb_s1;
	logic signed [PROD_W-1:0] sa_sb_s1, ca_cg_s1, ca_sg_s1, cb_sg_s1, cb_cg_s1;
	logic signed [WW-1:0]     sb_s1, sg_s1, cg_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ca_cb_s1 <= PROD_W'(ca) * PROD_W'(cb);
			ca_sb_s1 <= PROD_W'(ca) * PROD_W'(sb);
			sa_cg_s1 <= PROD_W'(sa) * PROD_W'(cg);
			sa_sg_s1 <= PROD_W'(sa) * PROD_W'(sg);
			sa_cb_s1 <= PROD_W'(sa) * PROD_W'(cb);
			sa_sb_s1 <= PROD_W'(sa) * PROD_W'(sb);
			ca_cg_s1 <= PROD_W'(ca) * PROD_W'(cg);
			ca_sg_s1 <= PROD_W'(ca) * PROD_W'(sg);
			cb_sg_s1 <= PROD_W'(cb) * PROD_W'(sg);
			cb_cg_s1 <= PROD_W'(cb) * PROD_W'(cg);
			sb_s1    <= sb;
			sg_s1    <= sg;
			cg_s1    <= cg;
		end
	end

	// s2: round pair products back to Q30
	logic signed [WW-1:0] ca_cb_s2, ca_sb_s2, sa_cg_s2, sa_sg_s2, sa_cb_s2;
	logic signed [WW-1:0] sa_sb_s2, ca_cg_s2, ca_sg_s2, cb_sg_s2, cb_cg_s2;
	logic signed [WW-1:0] sb_s2, sg_s2, cg_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ca_cb_s2 <= rmul(ca_cb_s1);
			ca_sb_s2 <= rmul(ca_sb_s1);
			sa_cg_s2 <= rmul(sa_cg_s1);
			sa_sg_s2 <= rmul(sa_sg_s1);
			sa_cb_s2 <= rmul(sa_cb_s1);
			sa_sb_s2 <= rmul(sa_sb_s1);
			ca_cg_s2 <= rmul(ca_cg_s1);
			ca_sg_s2 <= rmul(ca_sg_s1);
			cb_sg_s2 <= rmul(cb_sg_s1);
			cb_cg_s2 <= rmul(cb_cg_s1);
			sb_s2    <= sb_s1;
			sg_s2    <= sg_s1;
			cg_s2    <= cg_s1;
		end
	end

	// s3: raw triple products
	logic signed [PROD_W-1:0] t01_s3, t02_s3, t11_s3, t12_s3;
	logic signed [WW-1:0]     ca_cb_s3, sa_cg_s3, sa_sg_s3, sa_cb_s3;
	logic signed [WW-1:0]     ca_cg_s3, ca_sg_s3, cb_sg_s3, cb_cg_s3, sb_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			t01_s3   <= PROD_W'(ca_sb_s2) * PROD_W'(sg_s2);
			t02_s3   <= PROD_W'(ca_sb_s2) * PROD_W'(cg_s2);
			t11_s3   <= PROD_W'(sa_sb_s2) * PROD_W'(sg_s2);
			t12_s3   <= PROD_W'(sa_sb_s2) * PROD_W'(cg_s2);
			ca_cb_s3 <= ca_cb_s2;
			sa_cg_s3 <= sa_cg_s2;
			sa_sg_s3 <= sa_sg_s2;
			sa_cb_s3 <= sa_cb_s2;
			ca_cg_s3 <= ca_cg_s2;
			ca_sg_s3 <= ca_sg_s2;
			cb_sg_s3 <= cb_sg_s2;
			cb_cg_s3 <= cb_cg_s2;
			sb_s3    <= sb_s2;
		end
	end

	// s4: round triple products
	logic signed [WW-1:0] t01_s4, t02_s4, t11_s4, t12_s4;
	logic signed [WW-1:0] ca_cb_s4, sa_cg_s4, sa_sg_s4, sa_cb_s4;
	logic signed [WW-1:0] ca_cg_s4, ca_sg_s4, cb_sg_s4, cb_cg_s4, sb_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			t01_s4   <= rmul(t01_s3);
			t02_s4   <= rmul(t02_s3);
			t11_s4   <= rmul(t11_s3);
			t12_s4   <= rmul(t12_s3);
			ca_cb_s4 <= ca_cb_s3;
			sa_cg_s4 <= sa_cg_s3;
			sa_sg_s4 <= sa_sg_s3;
			sa_cb_s4 <= sa_cb_s3;
			ca_cg_s4 <= ca_cg_s3;
			ca_sg_s4 <= ca_sg_s3;
			cb_sg_s4 <= cb_sg_s3;
			cb_cg_s4 <= cb_cg_s3;
			sb_s4    <= sb_s3;
		end
	end

	// s5: entry sums in Q30
	logic signed [SUM_W-1:0] sum_s5 [N_ENTRY];

	always_ff @(posedge clk) begin
		if (en[4]) begin
			sum_s5[E00] <= SUM_W'(ca_cb_s4);
			sum_s5[E01] <= SUM_W'(t01_s4) - SUM_W'(sa_cg_s4);
			sum_s5[E02] <= SUM_W'(t02_s4) + SUM_W'(sa_sg_s4);
			sum_s5[E10] <= SUM_W'(sa_cb_s4);
			sum_s5[E11] <= SUM_W'(t11_s4) + SUM_W'(ca_cg_s4);
			sum_s5[E12] <= SUM_W'(t12_s4) - SUM_W'(ca_sg_s4);
			sum_s5[E20] <= -SUM_W'(sb_s4);
			sum_s5[E21] <= SUM_W'(cb_sg_s4);
			sum_s5[E22] <= SUM_W'(cb_cg_s4);
		end
	end

	// s6: round to coefficient format and clamp to unity
	entry_t rot_s6 [N_ENTRY];

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int e = 0; e < N_ENTRY; e++) begin
				rot_s6[e] <= to_entry(sum_s5[e]);
			end
		end
	end

	assign rot = rot_s6;

endmodule

`default_nettype wire

### rtl/entity_rotation_transform.sv
// Top level: entity pose in, Z*Y*X rotation matrix and translation out.
//
// Usage
//   Slave channel s_*: one transaction is one pose (yaw, pitch, roll as binary
//   angles, full turn = 2^16, and three 32-bit origin coordinates). Pitch and
//   roll are negated before their rotations about Y and X.
//   Master channel m_*: one transaction per pose, nine Q1.16 rotation entries
//   (saturated to +-1.0) followed by the origin copied unchanged.
//   Pipeline: 32 CORDIC stages, then 6 composition stages; the result is
//   offered on m_tvalid from the last composition stage.
//   Throughput: one pose per cycle while s_tready is high, set by the
//   one-step-per-stage CORDIC and the fully pipelined product path.
//   Stalls: each stage holds its own valid bit. A stage advances when it is
//   empty or the stage after it advances, so bubbles collapse and new poses
//   are still taken while a finished result waits on m_tready. s_tready
//   drops only when every stage is full and the output is stalled; it is a
//   combinational function of m_tready and the stage valids.
//   Reset (arst_n low): all stage valids clear, the pipeline is empty and
//   s_tready is high once reset is released. Data registers are not reset.
`default_nettype none

module entity_rotation_transform (
	input  logic                               clk,
	input  logic                               arst_n,
	// slave side
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// from bit 0: yaw_angle, pitch_angle, roll_angle, origin_x, origin_y, origin_z
	input  logic [ert_pkg::IN_TDATA_W-1:0]     s_tdata,
	// master side
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// from bit 0: m00, m01, m02, m10, m11, m12, m20, m21, m22,
	// trans_x, trans_y, trans_z, zero pad
	output logic [ert_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import ert_pkg::*;

	localparam int NST = PIPE_STAGES;

	// angle masked to ANGLE_BITS and scaled to a 2^32 turn; optional negate
	function automatic logic [TURN_W-1:0] to_turn(input logic [ANGLE_W-1:0] a,
		input logic neg);
		logic [TURN_W-1:0] t;
		t = (TURN_W'(a) & ANGLE_MASK) << TURN_SHIFT;
		return neg ? (TURN_W'(0) - t) : t;
	endfunction

	// input field unpack
	logic [ANGLE_W-1:0]    yaw_angle, pitch_angle, roll_angle;
	logic [ORIG_BUS_W-1:0] origin_in;

	assign yaw_angle   = s_tdata[0 +: ANGLE_W];
	assign pitch_angle = s_tdata[ANGLE_W +: ANGLE_W];
	assign roll_angle  = s_tdata[2*ANGLE_W +: ANGLE_W];
	assign origin_in   = s_tdata[3*ANGLE_W +: ORIG_BUS_W];

	// per-stage valids and advance enables
	logic [NST-1:0] vld_q;
	logic [NST-1:0] adv;

	assign adv[NST-1] = !vld_q[NST-1] || m_tready;
	for (genvar k = 0; k < NST - 1; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k+1];
	end

	assign s_tready = adv[0];
	assign m_tvalid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// origin rides a delay line matched to the datapath
	logic [ORIG_BUS_W-1:0] orig_q [NST];

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			orig_q[0] <= origin_in;
		end
		for (int k = 1; k < NST; k++) begin
			if (adv[k]) begin
				orig_q[k] <= orig_q[k-1];
			end
		end
	end

	// three CORDIC lanes share the stage enables
	sincos_t yaw_sc, pitch_sc, roll_sc;
	trig_t   trig;

	ert_cordic u_cordic_yaw (
		.clk    (clk),
		.en     (adv[CORDIC_STAGES-1:0]),
		.turn   (to_turn(yaw_angle, 1'b0)),
		.result (yaw_sc)
	);

	ert_cordic u_cordic_pitch (
		.clk    (clk),
		.en     (adv[CORDIC_STAGES-1:0]),
		.turn   (to_turn(pitch_angle, 1'b1)),
		.result (pitch_sc)
	);

	ert_cordic u_cordic_roll (
		.clk    (clk),
		.en     (adv[CORDIC_STAGES-1:0]),
		.turn   (to_turn(roll_angle, 1'b1)),
		.result (roll_sc)
	);

	assign trig = '{yaw: yaw_sc, pitch: pitch_sc, roll: roll_sc};

	entry_t rot [N_ENTRY];

	ert_compose u_compose (
		.clk  (clk),
		.en   (adv[NST-1:CORDIC_STAGES]),
		.trig (trig),
		.rot  (rot)
	);

	// output pack; the last compose stage is the output register
	assign m_tdata = {{OUT_PAD_W{1'b0}}, orig_q[NST-1],
		rot[E22], rot[E21], rot[E20], rot[E12], rot[E11], rot[E10],
		rot[E02], rot[E01], rot[E00]};

	// an empty output stage means the whole chain can move
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("s_tready low while output stage empty");

	// a draining sink never back-pressures the source
	a_ready_when_sink_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("s_tready low while m_tready high");

	// a full pipe with a stalled sink must refuse new poses
	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		((&vld_q) && !m_tready) |-> !s_tready)
		else $error("pose accepted into a full stalled pipeline");

endmodule

`default_nettype wire
